@@ hw/rtl/laserdisc_serial_command_decoder_top_defines.svh @@
// Assertion helpers for the laserdisc command decoder.
`ifndef LASERDISC_SERIAL_COMMAND_DECODER_TOP_DEFINES_SVH
`define LASERDISC_SERIAL_COMMAND_DECODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDDEC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never be seen.
`define LDDEC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ hw/rtl/lddec_pkg.sv @@
`timescale 1ns / 1ps

package lddec_pkg;

  localparam int DIGIT_SLOTS_DEF = 5;
  localparam int QUEUE_DEPTH     = 2;
  localparam int FRAME_W         = 17;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;
  localparam int TICKS_W         = 4;

  localparam logic [TICKS_W-1:0] ACK_TICKS_RESET = 4'd4;

  localparam logic [7:0] BYTE_PREFIX   = 8'hA8;
  localparam logic [7:0] BYTE_SYNC     = 8'h57;
  localparam logic [7:0] CMD_PREV_INIT = 8'hFF;
  localparam logic [7:0] CMD_DIGIT_MAX = 8'h09;
  localparam logic [7:0] CMD_REJECT    = 8'h16;
  localparam logic [7:0] CMD_PLAY      = 8'h17;
  localparam logic [7:0] CMD_PAUSE     = 8'h18;
  localparam logic [7:0] CMD_FRAME     = 8'h41;
  localparam logic [7:0] CMD_SEARCH    = 8'h42;
  localparam logic [7:0] CMD_CLEAR     = 8'h45;
  localparam logic [7:0] CMD_AUDIO_R   = 8'h49;
  localparam logic [7:0] CMD_STEREO    = 8'h4A;
  localparam logic [7:0] CMD_AUDIO_L   = 8'h4B;
  localparam logic [7:0] CMD_STEP_REV  = 8'h50;
  localparam logic [7:0] CMD_STEP_FWD  = 8'h54;
  localparam logic [7:0] CMD_ESCAPE    = 8'h5F;
  localparam logic [7:0] ESC_NOP_A     = 8'h02;
  localparam logic [7:0] ESC_NOP_B     = 8'h03;
  localparam logic [7:0] ESC_SQ_ON     = 8'h04;
  localparam logic [7:0] ESC_SQ_OFF    = 8'h05;
  localparam logic [7:0] ESC_NOP_C     = 8'h06;
  localparam logic [7:0] ESC_NOP_D     = 8'h07;

  localparam logic [2:0] ST_STOPPED  = 3'd0;
  localparam logic [2:0] ST_PLAYING  = 3'd1;
  localparam logic [2:0] ST_PAUSED   = 3'd2;
  localparam logic [2:0] ST_EJECTED  = 3'd3;
  localparam logic [2:0] ST_SEARCH   = 3'd4;
  localparam logic [2:0] ST_SPINUP   = 3'd5;

  localparam logic ERR_UNKNOWN = 1'b0;
  localparam logic ERR_STATUS  = 1'b1;

  localparam logic [APB_AW-1:0] REG_ACK_HOLD_ADDR = '0;

  typedef enum logic [3:0] {
    ACT_PLAY    = 4'd0,
    ACT_PAUSE   = 4'd1,
    ACT_STOP    = 4'd2,
    ACT_EJECT   = 4'd3,
    ACT_STEP    = 4'd4,
    ACT_SEARCH  = 4'd5,
    ACT_AUDIO   = 4'd6,
    ACT_SQUELCH = 4'd7,
    ACT_ERROR   = 4'd8,
    ACT_ACK     = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_FRAME_OK  = 2'd1,
    OP_FRAME_ERR = 2'd2,
    OP_COMMAND   = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [7:0]         value;
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame;
  } op_t;

  typedef struct packed {
    action_e            action;
    logic [FRAME_W-1:0] frame_number;
    logic               step_backward;
    logic               left_on;
    logic               right_on;
    logic               squelch_on;
    logic               error_code;
    logic [7:0]         error_value;
    logic               ack_active;
  } res_t;

  typedef struct packed {
    logic accum;
    logic ack_level;
  } back_stat_t;

endpackage

@@ hw/rtl/lddec_if.sv @@
`timescale 1ns / 1ps

interface lddec_in_if import lddec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         byte_value;
  logic [2:0]         player_status;
  logic [FRAME_W-1:0] current_frame;

  modport source (output valid, cmd, byte_value, player_status, current_frame, input ready);
  modport sink   (input valid, cmd, byte_value, player_status, current_frame, output ready);
endinterface

interface lddec_out_if import lddec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic [FRAME_W-1:0] frame_number;
  logic               step_backward;
  logic               left_on;
  logic               right_on;
  logic               squelch_on;
  logic               error_code;
  logic [7:0]         error_value;
  logic               ack_active;

  modport source (output valid, action, frame_number, step_backward, left_on, right_on,
                  squelch_on, error_code, error_value, ack_active, input ready);
  modport sink   (input valid, action, frame_number, step_backward, left_on, right_on,
                  squelch_on, error_code, error_value, ack_active, output ready);
endinterface

@@ hw/rtl/laserdisc_serial_command_decoder_top.sv @@
`timescale 1ns / 1ps
`include "laserdisc_serial_command_decoder_top_defines.svh"

// Serial remote command decoder. A front stage takes one input beat per cycle
// while the queue is not full, checks the A8/57/command/complement framing and
// queues a classified entry in a two-entry queue. The back stage runs one entry
// per cycle when not accumulating a search and holds its result in an output
// register. It takes no entry while that register holds a result not yet taken,
// so the queue absorbs up to two more input beats and the input then stalls
// until the result is taken. A search to an entered frame number runs the
// multiply-by-ten accumulate loop over the stored digits (at most DigitSlots),
// which walks the digit ring one digit a cycle in the back stage.
// The acknowledge hold length is the one APB register at byte address 0.

module laserdisc_serial_command_decoder_top import lddec_pkg::*; #(
  parameter int DigitSlots = DIGIT_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o,
  lddec_in_if.sink          in_i,
  lddec_out_if.source       out_o
);

  logic [TICKS_W-1:0] ack_ticks_q;
  logic               reg_sel;
  logic               q_push, q_pop, q_full, q_empty;
  op_t                q_in, q_out;
  back_stat_t         back_stat;
  logic               ack_prev_q;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[APB_AW-1] == REG_ACK_HOLD_ADDR[APB_AW-1]);
  assign prdata_o = reg_sel ? {{(APB_DW-TICKS_W){1'b0}}, ack_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_ticks_q <= ACK_TICKS_RESET;
      ack_prev_q  <= 1'b0;
    end else begin
      if (psel_i && penable_i && pwrite_i && reg_sel) begin
        ack_ticks_q <= pwdata_i[TICKS_W-1:0];
      end
      ack_prev_q <= back_stat.ack_level;
    end
  end

  lddec_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (q_in)
  );

  lddec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  lddec_back #(
    .DigitSlots (DigitSlots)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ack_ticks_i (ack_ticks_q),
    .op_valid_i  (!q_empty),
    .op_i        (q_out),
    .op_pop_o    (q_pop),
    .stat_o      (back_stat),
    .out_o       (out_o)
  );

  `LDDEC_ASSERT_NEVER(a_no_overflow, q_push && q_full, "queue pushed while full")
  `LDDEC_ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "queue popped while empty")
  `LDDEC_ASSERT_IMPLIES(a_accum_slot_free, back_stat.accum, !out_o.valid, "accumulate with result pending")
  `LDDEC_ASSERT_IMPLIES(a_ack_reported, back_stat.ack_level != ack_prev_q, out_o.valid && out_o.action == ACT_ACK && out_o.ack_active == back_stat.ack_level, "ack level change without result")

endmodule

@@ hw/rtl/lddec_fifo.sv @@
`timescale 1ns / 1ps

module lddec_fifo import lddec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  pop_data_o,
  output logic empty_o
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t            mem_q [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QW:0]    cnt_q, cnt_d;

  function automatic logic [QW-1:0] ptr_next(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == (QW+1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + (QW+1)'(push_i) - (QW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/lddec_front.sv @@
`timescale 1ns / 1ps

module lddec_front import lddec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lddec_in_if.sink   in_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output op_t        q_op_o
);

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_SYNC   = 4'b0010,
    PH_CMD    = 4'b0100,
    PH_CPL    = 4'b1000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] pending_q, pending_d;

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  always_comb begin
    phase_d       = phase_q;
    pending_d     = pending_q;
    q_op_o.kind   = OP_FRAME_OK;
    q_op_o.value  = in_i.byte_value;
    q_op_o.status = in_i.player_status;
    q_op_o.frame  = in_i.current_frame;
    if (in_i.cmd) begin
      q_op_o.kind = OP_TICK;
    end else begin
      case (phase_q)
        PH_PREFIX: begin
          if (in_i.byte_value == BYTE_PREFIX) begin
            phase_d = PH_SYNC;
          end else begin
            q_op_o.kind = OP_FRAME_ERR;
          end
        end
        PH_SYNC: begin
          if (in_i.byte_value == BYTE_SYNC) begin
            phase_d = PH_CMD;
          end else begin
            phase_d     = PH_PREFIX;
            q_op_o.kind = OP_FRAME_ERR;
          end
        end
        PH_CMD: begin
          pending_d = in_i.byte_value;
          phase_d   = PH_CPL;
        end
        PH_CPL: begin
          phase_d = PH_PREFIX;
          if (in_i.byte_value != ~pending_q) begin
            q_op_o.kind = OP_FRAME_ERR;
          end else begin
            q_op_o.kind  = OP_COMMAND;
            q_op_o.value = pending_q;
          end
        end
        default: begin
          phase_d = PH_PREFIX;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX;
      pending_q <= '0;
    end else if (q_push_o) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

endmodule

@@ hw/rtl/lddec_back.sv @@
`timescale 1ns / 1ps

module lddec_back import lddec_pkg::*; #(
  parameter int DigitSlots = DIGIT_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [TICKS_W-1:0] ack_ticks_i,
  input  logic               op_valid_i,
  input  op_t                op_i,
  output logic               op_pop_o,
  output back_stat_t         stat_o,
  lddec_out_if.source        out_o
);

  localparam int IDX_W = (DigitSlots > 1) ? $clog2(DigitSlots) : 1;
  localparam int CNT_W = $clog2(DigitSlots + 1);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_ACCUM = 2'b10
  } back_state_e;

  back_state_e        state_q, state_d;
  logic [3:0]         store_q [DigitSlots];
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d, n_q, n_d;
  logic [TICKS_W-1:0] hold_q, hold_d;
  logic               fresh_q, fresh_d, ack_q, ack_d, entry_q, entry_d;
  logic               clr_q, clr_d, esc_q, esc_d;
  logic [7:0]         prev_q, prev_d;
  logic [FRAME_W-1:0] acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, res_d;
  logic               res_load;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [3:0]         wdata;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DigitSlots - 1)) ? '0 : i + 1'b1;
  endfunction

  assign stat_o.accum     = (state_q == BK_ACCUM);
  assign stat_o.ack_level = ack_q;

  assign out_o.valid         = out_valid_q;
  assign out_o.action        = out_q.action;
  assign out_o.frame_number  = out_q.frame_number;
  assign out_o.step_backward = out_q.step_backward;
  assign out_o.left_on       = out_q.left_on;
  assign out_o.right_on      = out_q.right_on;
  assign out_o.squelch_on    = out_q.squelch_on;
  assign out_o.error_code    = out_q.error_code;
  assign out_o.error_value   = out_q.error_value;
  assign out_o.ack_active    = out_q.ack_active;

  always_comb begin
    logic             en;
    logic             reload;
    logic [7:0]       c;
    logic [2:0]       st;
    logic [IDX_W-1:0] h;
    logic [CNT_W-1:0] cnt;

    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    idx_d    = idx_q;
    count_d  = count_q;
    n_d      = n_q;
    hold_d   = hold_q;
    fresh_d  = fresh_q;
    ack_d    = ack_q;
    entry_d  = entry_q;
    clr_d    = clr_q;
    esc_d    = esc_q;
    prev_d   = prev_q;
    acc_d    = acc_q;
    res_d    = '0;
    res_load = 1'b0;
    op_pop_o = 1'b0;
    we       = 1'b0;
    waddr    = tail_q;
    wdata    = op_i.value[3:0];
    en       = 1'b0;
    reload   = 1'b1;
    c        = op_i.value;
    st       = op_i.status;
    h        = head_q;
    cnt      = count_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      BK_IDLE: begin
        if (op_valid_i && (!out_valid_q || out_o.ready)) begin
          op_pop_o = 1'b1;
          case (op_i.kind)
            OP_TICK: begin
              en = (hold_q != '0);
              if (fresh_q) begin
                fresh_d = 1'b0;
                en      = 1'b0;
              end
              if (st == ST_SEARCH || st == ST_SPINUP) begin
                en = 1'b1;
              end
              if (en != ack_q) begin
                ack_d            = en;
                res_load         = 1'b1;
                res_d.action     = ACT_ACK;
                res_d.ack_active = en;
              end
              if (hold_q != '0) begin
                hold_d = hold_q - 1'b1;
              end
            end
            OP_FRAME_OK: begin
              if (hold_q != '0) begin
                hold_d = ack_ticks_i;
              end
            end
            OP_FRAME_ERR: begin
              res_load          = 1'b1;
              res_d.action      = ACT_ERROR;
              res_d.error_code  = ERR_UNKNOWN;
              res_d.error_value = c;
            end
            OP_COMMAND: begin
              if (c == prev_q && hold_q != '0) begin
                hold_d = ack_ticks_i;
              end else begin
                fresh_d = 1'b1;
                if (!esc_q) begin
                  if (c <= CMD_DIGIT_MAX) begin
                    if (st != ST_STOPPED) begin
                      if (clr_q) begin
                        h     = tail_q;
                        cnt   = '0;
                        clr_d = 1'b0;
                      end
                      we     = 1'b1;
                      tail_d = ring_next(tail_q);
                      if (cnt == CNT_W'(DigitSlots)) begin
                        head_d  = ring_next(h);
                        count_d = cnt;
                      end else begin
                        head_d  = h;
                        count_d = cnt + 1'b1;
                      end
                    end else begin
                      reload = 1'b0;
                    end
                  end else begin
                    case (c)
                      CMD_REJECT: begin
                        reload = 1'b0;
                        if (st == ST_PLAYING || st == ST_PAUSED) begin
                          res_load     = 1'b1;
                          res_d.action = ACT_STOP;
                        end else if (st == ST_STOPPED) begin
                          res_load     = 1'b1;
                          res_d.action = ACT_EJECT;
                        end else if (st != ST_EJECTED) begin
                          res_load          = 1'b1;
                          res_d.action      = ACT_ERROR;
                          res_d.error_code  = ERR_STATUS;
                          res_d.error_value = {5'b0, st};
                        end
                      end
                      CMD_PLAY: begin
                        res_load     = 1'b1;
                        res_d.action = ACT_PLAY;
                      end
                      CMD_PAUSE: begin
                        res_load = 1'b1;
                        if (st == ST_PAUSED) begin
                          res_d.action       = ACT_SEARCH;
                          res_d.frame_number = op_i.frame;
                        end else begin
                          res_d.action = ACT_PAUSE;
                        end
                      end
                      CMD_FRAME: begin
                        if (st != ST_STOPPED) begin
                          entry_d = 1'b1;
                          clr_d   = 1'b1;
                        end else begin
                          reload = 1'b0;
                        end
                      end
                      CMD_SEARCH: begin
                        if (entry_q && st != ST_STOPPED) begin
                          entry_d = 1'b0;
                          if (count_q == '0) begin
                            res_load     = 1'b1;
                            res_d.action = ACT_SEARCH;
                          end else begin
                            state_d = BK_ACCUM;
                            acc_d   = '0;
                            idx_d   = head_q;
                            n_d     = count_q;
                          end
                        end else begin
                          reload = 1'b0;
                        end
                      end
                      CMD_CLEAR: begin
                        esc_d = 1'b0;
                        if (entry_q) begin
                          if (count_q != '0) begin
                            head_d  = tail_q;
                            count_d = '0;
                          end else begin
                            entry_d = 1'b0;
                          end
                        end
                      end
                      CMD_AUDIO_R, CMD_STEREO, CMD_AUDIO_L: begin
                        if (c == CMD_STEREO && st == ST_EJECTED) begin
                          reload = 1'b0;
                        end
                        res_load       = 1'b1;
                        res_d.action   = ACT_AUDIO;
                        res_d.left_on  = (c != CMD_AUDIO_R);
                        res_d.right_on = (c != CMD_AUDIO_L);
                      end
                      CMD_STEP_REV, CMD_STEP_FWD: begin
                        res_load            = 1'b1;
                        res_d.action        = ACT_STEP;
                        res_d.step_backward = (c == CMD_STEP_REV);
                      end
                      CMD_ESCAPE: begin
                        esc_d  = 1'b1;
                        reload = 1'b0;
                      end
                      default: begin
                        res_load          = 1'b1;
                        res_d.action      = ACT_ERROR;
                        res_d.error_code  = ERR_UNKNOWN;
                        res_d.error_value = c;
                      end
                    endcase
                  end
                end else begin
                  esc_d = 1'b0;
                  case (c)
                    ESC_NOP_A, ESC_NOP_B, ESC_NOP_C, ESC_NOP_D: begin
                      reload = 1'b1;
                    end
                    ESC_SQ_ON, ESC_SQ_OFF: begin
                      res_load         = 1'b1;
                      res_d.action     = ACT_SQUELCH;
                      res_d.squelch_on = (c == ESC_SQ_ON);
                    end
                    CMD_CLEAR: begin
                      if (entry_q) begin
                        if (count_q != '0) begin
                          head_d  = tail_q;
                          count_d = '0;
                        end else begin
                          entry_d = 1'b0;
                        end
                      end
                    end
                    CMD_ESCAPE: begin
                      esc_d  = 1'b1;
                      reload = 1'b0;
                    end
                    default: begin
                      res_load          = 1'b1;
                      res_d.action      = ACT_ERROR;
                      res_d.error_code  = ERR_UNKNOWN;
                      res_d.error_value = c;
                    end
                  endcase
                end
                prev_d = c;
                if (reload) begin
                  hold_d = ack_ticks_i;
                end
              end
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_ACCUM: begin
        acc_d = acc_q * FRAME_W'(10) + FRAME_W'(store_q[idx_q]);
        idx_d = ring_next(idx_q);
        n_d   = n_q - 1'b1;
        if (n_q == CNT_W'(1)) begin
          state_d            = BK_IDLE;
          res_load           = 1'b1;
          res_d.action       = ACT_SEARCH;
          res_d.frame_number = acc_d;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (res_load) begin
      out_q <= res_d;
    end
    acc_q <= acc_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
      hold_q      <= '0;
      fresh_q     <= 1'b0;
      ack_q       <= 1'b0;
      entry_q     <= 1'b0;
      clr_q       <= 1'b0;
      esc_q       <= 1'b0;
      prev_q      <= CMD_PREV_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      n_q         <= n_d;
      hold_q      <= hold_d;
      fresh_q     <= fresh_d;
      ack_q       <= ack_d;
      entry_q     <= entry_d;
      clr_q       <= clr_d;
      esc_q       <= esc_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lddec_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 24;
  localparam int MAX_REPORTS     = 10;

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_SYNC   = 2'd1;
  localparam logic [1:0] PH_CODE   = 2'd2;
  localparam logic [1:0] PH_CHECK  = 2'd3;

  localparam int FLAW_NONE   = 0;
  localparam int FLAW_PREFIX = 1;
  localparam int FLAW_SYNC   = 2;
  localparam int FLAW_CHECK  = 3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel_i;
  logic              penable_i;
  logic              pwrite_i;
  logic [APB_AW-1:0] paddr_i;
  logic [APB_DW-1:0] pwdata_i;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;

  lddec_in_if  in_if ();
  lddec_out_if out_if ();

  laserdisc_serial_command_decoder_top u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #1 clk_i = ~clk_i;

  // decoder state mirror
  logic [TICKS_W-1:0] hold_ticks;
  logic [1:0]         fr_phase;
  logic               entry_on;
  logic [3:0]         digit_ring [DIGIT_SLOTS_DEF];
  int                 ring_head;
  int                 ring_tail;
  int                 ring_count;
  logic [3:0]         hold_cnt;
  logic               fresh_cmd;
  logic               ack_lvl;
  logic               clear_pending;
  logic [7:0]         pend_cmd;
  logic [7:0]         prev_cmd;
  logic               esc_on;

  res_t        expected_actions [$];
  res_t        seen_action;
  res_t        want_action;
  int          items_sent;
  int          error_count;
  bit          gaps_on;
  bit          hold_off_req;
  logic [7:0]  last_code;

  task automatic reset_decoder_state();
    hold_ticks    = ACK_TICKS_RESET;
    fr_phase      = PH_PREFIX;
    entry_on      = 1'b0;
    foreach (digit_ring[i]) digit_ring[i] = '0;
    ring_head     = 0;
    ring_tail     = 0;
    ring_count    = 0;
    hold_cnt      = '0;
    fresh_cmd     = 1'b0;
    ack_lvl       = 1'b0;
    clear_pending = 1'b0;
    pend_cmd      = '0;
    prev_cmd      = CMD_PREV_INIT;
    esc_on        = 1'b0;
  endtask

  function automatic void push_digit(input logic [3:0] d);
    if (clear_pending) begin
      ring_head     = ring_tail;
      ring_count    = 0;
      clear_pending = 1'b0;
    end
    ring_tail = ring_tail % DIGIT_SLOTS_DEF;
    digit_ring[ring_tail] = d;
    ring_tail = (ring_tail + 1) % DIGIT_SLOTS_DEF;
    ring_count++;
    if (ring_count > DIGIT_SLOTS_DEF) begin
      ring_head  = (ring_head % DIGIT_SLOTS_DEF + 1) % DIGIT_SLOTS_DEF;
      ring_count = DIGIT_SLOTS_DEF;
    end
  endfunction

  function automatic logic [FRAME_W-1:0] entered_frame();
    int unsigned v;
    int          idx;
    int          n;
    v   = 0;
    idx = ring_head % DIGIT_SLOTS_DEF;
    n   = (ring_count > DIGIT_SLOTS_DEF) ? DIGIT_SLOTS_DEF : ring_count;
    while (n != 0) begin
      v   = v * 10 + digit_ring[idx];
      idx = (idx + 1) % DIGIT_SLOTS_DEF;
      n--;
    end
    return v[FRAME_W-1:0];
  endfunction

  function automatic void clear_entry();
    esc_on = 1'b0;
    if (entry_on) begin
      if (ring_count != 0) begin
        ring_head  = ring_tail;
        ring_count = 0;
      end else begin
        entry_on = 1'b0;
      end
    end
  endfunction

  function automatic bit predict_action(input logic c, input logic [7:0] b,
                                        input logic [2:0] st,
                                        input logic [FRAME_W-1:0] f, output res_t r);
    logic       en;
    logic       reload;
    logic [7:0] cm;
    bit         has;
    r   = '0;
    has = 1'b0;
    if (c) begin
      en = (hold_cnt != 0);
      if (fresh_cmd) begin
        fresh_cmd = 1'b0;
        en        = 1'b0;
      end
      if (st == ST_SEARCH || st == ST_SPINUP) en = 1'b1;
      if (en != ack_lvl) begin
        ack_lvl      = en;
        r.action     = ACT_ACK;
        r.ack_active = en;
        has          = 1'b1;
      end
      if (hold_cnt != 0) hold_cnt--;
      return has;
    end
    case (fr_phase)
      PH_PREFIX, PH_SYNC: begin
        if (b == ((fr_phase == PH_PREFIX) ? BYTE_PREFIX : BYTE_SYNC)) begin
          fr_phase = fr_phase + 2'd1;
          if (hold_cnt != 0) hold_cnt = hold_ticks;
          return 1'b0;
        end
        fr_phase      = PH_PREFIX;
        r.action      = ACT_ERROR;
        r.error_code  = ERR_UNKNOWN;
        r.error_value = b;
        return 1'b1;
      end
      PH_CODE: begin
        pend_cmd = b;
        fr_phase = PH_CHECK;
        if (hold_cnt != 0) hold_cnt = hold_ticks;
        return 1'b0;
      end
      default: begin
        fr_phase = PH_PREFIX;
        if (b != ~pend_cmd) begin
          r.action      = ACT_ERROR;
          r.error_code  = ERR_UNKNOWN;
          r.error_value = b;
          return 1'b1;
        end
      end
    endcase

    cm = pend_cmd;
    if (cm == prev_cmd && hold_cnt != 0) begin
      hold_cnt = hold_ticks;
      return 1'b0;
    end
    fresh_cmd = 1'b1;
    reload    = 1'b1;

    if (!esc_on) begin
      if (cm <= CMD_DIGIT_MAX) begin
        if (st != ST_STOPPED) push_digit(cm[3:0]);
        else reload = 1'b0;
      end else begin
        case (cm)
          CMD_REJECT: begin
            if (st == ST_PLAYING || st == ST_PAUSED) begin
              r.action = ACT_STOP;
              has      = 1'b1;
            end else if (st == ST_STOPPED) begin
              r.action = ACT_EJECT;
              has      = 1'b1;
            end else if (st != ST_EJECTED) begin
              r.action      = ACT_ERROR;
              r.error_code  = ERR_STATUS;
              r.error_value = {5'd0, st};
              has           = 1'b1;
            end
            reload = 1'b0;
          end
          CMD_PLAY: begin
            r.action = ACT_PLAY;
            has      = 1'b1;
          end
          CMD_PAUSE: begin
            if (st == ST_PAUSED) begin
              r.action       = ACT_SEARCH;
              r.frame_number = f;
            end else begin
              r.action = ACT_PAUSE;
            end
            has = 1'b1;
          end
          CMD_FRAME: begin
            if (st != ST_STOPPED) begin
              entry_on      = 1'b1;
              clear_pending = 1'b1;
            end else begin
              reload = 1'b0;
            end
          end
          CMD_SEARCH: begin
            if (entry_on && st != ST_STOPPED) begin
              entry_on       = 1'b0;
              r.action       = ACT_SEARCH;
              r.frame_number = entered_frame();
              has            = 1'b1;
            end else begin
              reload = 1'b0;
            end
          end
          CMD_CLEAR: clear_entry();
          CMD_AUDIO_R, CMD_STEREO, CMD_AUDIO_L: begin
            if (cm == CMD_STEREO && st == ST_EJECTED) reload = 1'b0;
            r.action   = ACT_AUDIO;
            r.left_on  = (cm != CMD_AUDIO_R);
            r.right_on = (cm != CMD_AUDIO_L);
            has        = 1'b1;
          end
          CMD_STEP_REV, CMD_STEP_FWD: begin
            r.action        = ACT_STEP;
            r.step_backward = (cm == CMD_STEP_REV);
            has             = 1'b1;
          end
          CMD_ESCAPE: begin
            esc_on = 1'b1;
            reload = 1'b0;
          end
          default: begin
            r.action      = ACT_ERROR;
            r.error_code  = ERR_UNKNOWN;
            r.error_value = cm;
            has           = 1'b1;
          end
        endcase
      end
    end else begin
      esc_on = 1'b0;
      case (cm)
        ESC_NOP_A, ESC_NOP_B, ESC_NOP_C, ESC_NOP_D: ;
        ESC_SQ_ON, ESC_SQ_OFF: begin
          r.action     = ACT_SQUELCH;
          r.squelch_on = (cm == ESC_SQ_ON);
          has          = 1'b1;
        end
        CMD_CLEAR: clear_entry();
        CMD_ESCAPE: begin
          esc_on = 1'b1;
          reload = 1'b0;
        end
        default: begin
          r.action      = ACT_ERROR;
          r.error_code  = ERR_UNKNOWN;
          r.error_value = cm;
          has           = 1'b1;
        end
      endcase
    end

    prev_cmd = cm;
    if (reload) hold_cnt = hold_ticks;
    return has;
  endfunction

  function automatic bit same_action(input res_t a, input res_t b);
    return a.action == b.action && a.frame_number == b.frame_number &&
           a.step_backward == b.step_backward && a.left_on == b.left_on &&
           a.right_on == b.right_on && a.squelch_on == b.squelch_on &&
           a.error_code == b.error_code && a.error_value == b.error_value &&
           a.ack_active == b.ack_active;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_action.action        = action_e'(out_if.action);
      seen_action.frame_number  = out_if.frame_number;
      seen_action.step_backward = out_if.step_backward;
      seen_action.left_on       = out_if.left_on;
      seen_action.right_on      = out_if.right_on;
      seen_action.squelch_on    = out_if.squelch_on;
      seen_action.error_code    = out_if.error_code;
      seen_action.error_value   = out_if.error_value;
      seen_action.ack_active    = out_if.ack_active;
      if (expected_actions.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected action %0d at %0t", out_if.action, $realtime);
      end else begin
        want_action = expected_actions.pop_front();
        if (!same_action(want_action, seen_action)) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("action mismatch at %0t", $realtime);
            $display("  expected act=%0d frame=%0d back=%b l=%b r=%b sq=%b ec=%b ev=%h ack=%b",
                     want_action.action, want_action.frame_number,
                     want_action.step_backward, want_action.left_on, want_action.right_on,
                     want_action.squelch_on, want_action.error_code,
                     want_action.error_value, want_action.ack_active);
            $display("  actual   act=%0d frame=%0d back=%b l=%b r=%b sq=%b ec=%b ev=%h ack=%b",
                     seen_action.action, seen_action.frame_number,
                     seen_action.step_backward, seen_action.left_on, seen_action.right_on,
                     seen_action.squelch_on, seen_action.error_code,
                     seen_action.error_value, seen_action.ack_active);
          end
        end
      end
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [FRAME_W-1:0] rand_frame();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'($urandom_range(0, 99999));
    return f;
  endfunction

  function automatic logic [2:0] pick_status();
    int         r;
    logic [2:0] st;
    r = $urandom_range(0, 99);
    if (r < 15) st = ST_STOPPED;
    else if (r < 45) st = ST_PLAYING;
    else if (r < 65) st = ST_PAUSED;
    else if (r < 75) st = ST_EJECTED;
    else st = 3'($urandom_range(4, 7));
    return st;
  endfunction

  function automatic logic [7:0] pick_command();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) c = 8'($urandom_range(0, 9));
    else if (r < 37) c = CMD_FRAME;
    else if (r < 43) c = CMD_SEARCH;
    else if (r < 48) c = CMD_CLEAR;
    else if (r < 54) c = CMD_REJECT;
    else if (r < 60) c = CMD_PLAY;
    else if (r < 67) c = CMD_PAUSE;
    else if (r < 75) begin
      case ($urandom_range(0, 2))
        0:       c = CMD_AUDIO_R;
        1:       c = CMD_STEREO;
        default: c = CMD_AUDIO_L;
      endcase
    end else if (r < 82) c = ($urandom_range(0, 1) != 0) ? CMD_STEP_REV : CMD_STEP_FWD;
    else if (r < 86) c = CMD_ESCAPE;
    else c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_escaped();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = ESC_NOP_A;
      1:       c = ESC_NOP_B;
      2:       c = ESC_NOP_C;
      3:       c = ESC_NOP_D;
      4, 5:    c = ESC_SQ_ON;
      6:       c = ESC_SQ_OFF;
      7:       c = CMD_CLEAR;
      8:       c = CMD_ESCAPE;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic send_item(input logic c, input logic [7:0] b, input logic [2:0] st,
                           input logic [FRAME_W-1:0] f);
    res_t want;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= c;
    in_if.byte_value    <= b;
    in_if.player_status <= st;
    in_if.current_frame <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (predict_action(c, b, st, f, want)) expected_actions.push_back(want);
    items_sent++;
  endtask

  task automatic send_tick(input logic [2:0] st);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    send_item(1'b1, b, st, rand_frame());
  endtask

  task automatic send_cmd(input logic [7:0] code, input logic [2:0] st, input int flaw,
                          input logic [FRAME_W-1:0] f);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (flaw == FLAW_PREFIX) begin
      if (b == BYTE_PREFIX) b = ~b;
      send_item(1'b0, b, st, f);
    end else begin
      send_item(1'b0, BYTE_PREFIX, st, f);
      if (flaw == FLAW_SYNC) begin
        if (b == BYTE_SYNC) b = ~b;
        send_item(1'b0, b, st, f);
      end else begin
        send_item(1'b0, BYTE_SYNC, st, f);
        send_item(1'b0, code, st, f);
        if (b == 8'h00) b = 8'h80;
        send_item(1'b0, (flaw == FLAW_CHECK) ? (~code ^ b) : ~code, st, f);
      end
    end
    last_code = code;
  endtask

  task automatic drain_actions();
    in_if.valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_actions.size() != 0; i++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_hold_ticks(input logic [TICKS_W-1:0] v);
    drain_actions();
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= REG_ACK_HOLD_ADDR;
    pwdata_i  <= {{(APB_DW-TICKS_W){1'b0}}, v};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    hold_ticks = v;
  endtask

  task automatic run_random(input int n, input bit vary_gaps);
    int         target;
    int         pick;
    logic [2:0] st;
    logic [7:0] b;
    target = items_sent + n;
    st     = ST_PLAYING;
    while (items_sent < target) begin
      if (vary_gaps && $urandom_range(0, 40) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) st = pick_status();
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        send_cmd(pick_command(), st, FLAW_NONE, rand_frame());
      end else if (pick < 52) begin
        send_cmd(CMD_ESCAPE, st, FLAW_NONE, rand_frame());
        send_cmd(pick_escaped(), st, FLAW_NONE, rand_frame());
      end else if (pick < 62) begin
        if (st == ST_STOPPED && $urandom_range(0, 9) != 0) st = ST_PLAYING;
        send_cmd(CMD_FRAME, st, FLAW_NONE, rand_frame());
        repeat ($urandom_range(0, 7)) begin
          if ($urandom_range(0, 4) == 0) send_tick(st);
          send_cmd(8'($urandom_range(0, 9)), st, FLAW_NONE, rand_frame());
        end
        send_cmd(CMD_SEARCH, st, FLAW_NONE, rand_frame());
      end else if (pick < 69) begin
        send_cmd(last_code, st, FLAW_NONE, rand_frame());
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6))
          send_tick(($urandom_range(0, 3) == 0) ? pick_status() : st);
      end else if (pick < 95) begin
        send_cmd(pick_command(), st, $urandom_range(FLAW_PREFIX, FLAW_CHECK), rand_frame());
      end else begin
        b = 8'($urandom_range(0, 255));
        send_item(1'b0, b, st, rand_frame());
      end
    end
  endtask

  task automatic test_framing_and_basics();
    gaps_on = 1'b1;
    send_item(1'b0, 8'hFF, ST_PLAYING, rand_frame());
    send_item(1'b0, BYTE_PREFIX, ST_PLAYING, rand_frame());
    send_item(1'b0, 8'h00, ST_PLAYING, rand_frame());
    send_cmd(CMD_PLAY, ST_STOPPED, FLAW_CHECK, rand_frame());
    send_cmd(CMD_PLAY, 3'd7, FLAW_NONE, '0);
    send_cmd(CMD_PAUSE, ST_PAUSED, FLAW_NONE, FRAME_W'(99999));
    send_tick(ST_SEARCH);
    send_tick(ST_STOPPED);
    send_cmd(CMD_ESCAPE, ST_PLAYING, FLAW_NONE, rand_frame());
    send_cmd(ESC_SQ_ON, ST_PLAYING, FLAW_NONE, rand_frame());
  endtask

  task automatic test_hold_extremes();
    write_hold_ticks(4'd15);
    run_random(300, 1'b1);
    write_hold_ticks(4'd1);
    run_random(300, 1'b1);
  endtask

  task automatic test_output_backpressure();
    write_hold_ticks(TICKS_W'($urandom_range(2, 14)));
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_random(150, 1'b0);
  endtask

  task automatic test_mixed_traffic();
    repeat (4) begin
      write_hold_ticks(TICKS_W'($urandom_range(1, 15)));
      run_random(180, 1'b1);
    end
  endtask

  task automatic test_steady_stream();
    write_hold_ticks(ACK_TICKS_RESET);
    gaps_on = 1'b0;
    run_random(300, 1'b0);
  endtask

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    psel_i              <= 1'b0;
    penable_i           <= 1'b0;
    pwrite_i            <= 1'b0;
    paddr_i             <= '0;
    pwdata_i            <= '0;
    in_if.valid         <= 1'b0;
    in_if.cmd           <= 1'b0;
    in_if.byte_value    <= '0;
    in_if.player_status <= '0;
    in_if.current_frame <= '0;
    out_if.ready        <= 1'b0;
    items_sent   = 0;
    error_count  = 0;
    gaps_on      = 1'b0;
    hold_off_req = 1'b0;
    last_code    = CMD_PLAY;
    reset_decoder_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_framing_and_basics();
    test_hold_extremes();
    test_output_backpressure();
    test_mixed_traffic();
    test_steady_stream();

    drain_actions();
    error_count += expected_actions.size();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
